/* hw/rtl/crr_pkg.sv */
package crr_pkg;

   typedef logic [63:0] word_type;
   typedef logic [31:0] half_type;

   localparam int unsigned WordBits = 64;
   localparam int unsigned HalfBits = 32;

   localparam word_type STRIDE64 = 64'h9E37_79B9_7F4A_7C15;
   localparam half_type STRIDE32 = 32'h9E37_79B9;

   localparam word_type MIX64_K1 = 64'hBF58_476D_1CE4_E5B9;
   localparam word_type MIX64_K2 = 64'h94D0_49BB_1331_11EB;
   localparam half_type MIX32_K1 = 32'h21F0_AAAD;
   localparam half_type MIX32_K2 = 32'h735A_2D97;

   localparam int unsigned MIX64_SH1 = 30;
   localparam int unsigned MIX64_SH2 = 27;
   localparam int unsigned MIX64_SH3 = 31;
   localparam int unsigned MIX32_SH1 = 16;
   localparam int unsigned MIX32_SH2 = 15;
   localparam int unsigned MIX32_SH3 = 15;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SEED   = 2'd0;
   localparam csr_index_type CSR_STREAM = 2'd1;
   localparam csr_index_type CSR_WIDE   = 2'd2;

   localparam logic ACT_RAW    = 1'b0;
   localparam logic ACT_RANGED = 1'b1;

   // narrow mode keeps the upper half clear
   function automatic word_type trim(input logic wide, input word_type x);
      trim = wide ? x : {{HalfBits{1'b0}}, x[HalfBits-1:0]};
   endfunction

endpackage

/* hw/rtl/crr_mul.sv */
module crr_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              mul_start,
   input  crr_pkg::word_type mul_a,
   input  crr_pkg::word_type mul_b,
   output logic              mul_done,
   output crr_pkg::word_type mul_product
);
   import crr_pkg::*;

   // low 64 bits of a*b from three 32x32 partial products, one per cycle
   logic [1:0] step_ff, step_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   word_type   a_ff, a_in;
   word_type   b_ff, b_in;
   word_type   acc_ff, acc_in;

   half_type x, y;
   word_type prod;

   always_comb begin
      x = (step_ff == 2'd2) ? a_ff[WordBits-1:HalfBits] : a_ff[HalfBits-1:0];
      y = (step_ff == 2'd1) ? b_ff[WordBits-1:HalfBits] : b_ff[HalfBits-1:0];
      prod = word_type'(x) * word_type'(y);
   end

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (mul_start) begin
         a_in    = mul_a;
         b_in    = mul_b;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == 2'd0) begin
            acc_in = prod;
         end else begin
            acc_in = acc_ff + {prod[HalfBits-1:0], {HalfBits{1'b0}}};
         end
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign mul_done    = done_ff;
   assign mul_product = acc_ff;

endmodule

/* hw/rtl/crr_div.sv */
module crr_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              div_start,
   input  crr_pkg::word_type div_dividend,
   input  crr_pkg::word_type div_divisor,
   output logic              div_done,
   output crr_pkg::word_type div_remainder
);
   import crr_pkg::*;

   // restoring divider, one quotient bit a cycle, remainder only
   localparam int unsigned CntBits = $clog2(WordBits);

   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   word_type           rem_ff, rem_in;
   word_type           dvd_ff, dvd_in;
   word_type           dsr_ff, dsr_in;

   logic [WordBits:0] shifted;
   logic [WordBits:0] diff;

   always_comb begin
      shifted = {rem_ff, dvd_ff[WordBits-1]};
      diff    = shifted - {1'b0, dsr_ff};
   end

   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (div_start) begin
         rem_in  = '0;
         dvd_in  = div_dividend;
         dsr_in  = div_divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[WordBits] ? shifted[WordBits-1:0] : diff[WordBits-1:0];
         dvd_in = {dvd_ff[WordBits-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntBits'(WordBits - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_done      = done_ff;
   assign div_remainder = rem_ff;

endmodule

/* hw/rtl/counter_rng_with_range.sv */
// Raw draw: two mix rounds, each a multiply on one shared 32x32 multiplier; a ranged draw
// adds the bit-serial remainder; a zero-length ranged draw skips both and goes straight to
// the response. One item at a time: no new request until the response has been taken.
// Seed or stream write: reload.
// Reset: synchronous; seed 1, stream 0, wide mode; the reload follows, no port ready.
module counter_rng_with_range (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic signed [63:0]  req_range_start,
   input  logic [63:0]         req_range_len,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [63:0]         rsp_raw_value,
   output logic signed [63:0]  rsp_ranged_value,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  crr_pkg::csr_index_type csr_index,
   input  logic [63:0]         csr_wdata
);
   import crr_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SEED   = 4'd1;
   localparam logic [3:0] S_SEED_W = 4'd2;
   localparam logic [3:0] S_M1     = 4'd3;
   localparam logic [3:0] S_M1_W   = 4'd4;
   localparam logic [3:0] S_M2     = 4'd5;
   localparam logic [3:0] S_M2_W   = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_DIV_W  = 4'd8;
   localparam logic [3:0] S_RSP    = 4'd9;

   logic [3:0] state_ff, state_in;
   word_type   seed_ff, seed_in;
   half_type   stream_ff, stream_in;
   logic       wide_ff, wide_in;
   logic       reload_ff, reload_in;
   word_type   counter_ff, counter_in;
   word_type   z_ff, z_in;
   logic       action_ff, action_in;
   word_type   start_ff, start_in;
   word_type   len_ff, len_in;
   word_type   raw_ff, raw_in;
   word_type   ranged_ff, ranged_in;

   logic         mul_start, mul_done, div_start, div_done;
   word_type     mul_a, mul_b, mul_product, div_remainder;
   word_type     prod_t, fin, step_state;
   half_type     sum32;
   logic         req_beat, csr_beat, len_zero;

   crr_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .mul_start   (mul_start),
      .mul_a       (mul_a),
      .mul_b       (mul_b),
      .mul_done    (mul_done),
      .mul_product (mul_product)
   );

   crr_div u_div (
      .clock         (clock),
      .reset         (reset),
      .div_start     (div_start),
      .div_dividend  (raw_ff),
      .div_divisor   (trim(wide_ff, len_ff)),
      .div_done      (div_done),
      .div_remainder (div_remainder)
   );

   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign req_beat  = req_valid && req_ready;
   assign csr_beat  = csr_valid && csr_ready;

   assign rsp_raw_value    = raw_ff;
   assign rsp_ranged_value = $signed(ranged_ff);

   always_comb begin
      mul_start = (state_ff == S_SEED) || (state_ff == S_M1) || (state_ff == S_M2);
      div_start = (state_ff == S_DIV);
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SEED: begin
            mul_a = {{HalfBits{1'b0}}, stream_ff};
            mul_b = wide_ff ? STRIDE64 : {{HalfBits{1'b0}}, STRIDE32};
         end
         S_M1: begin
            mul_a = wide_ff ? (z_ff ^ (z_ff >> MIX64_SH1)) : (z_ff ^ (z_ff >> MIX32_SH1));
            mul_b = wide_ff ? MIX64_K1 : {{HalfBits{1'b0}}, MIX32_K1};
         end
         S_M2: begin
            mul_a = wide_ff ? (z_ff ^ (z_ff >> MIX64_SH2)) : (z_ff ^ (z_ff >> MIX32_SH2));
            mul_b = wide_ff ? MIX64_K2 : {{HalfBits{1'b0}}, MIX32_K2};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      prod_t     = trim(wide_ff, mul_product);
      fin        = wide_ff ? (prod_t ^ (prod_t >> MIX64_SH3)) : (prod_t ^ (prod_t >> MIX32_SH3));
      step_state = wide_ff ? (counter_ff + STRIDE64)
                           : {{HalfBits{1'b0}}, counter_ff[HalfBits-1:0] + STRIDE32};
      len_zero   = wide_ff ? (req_range_len == '0) : (req_range_len[HalfBits-1:0] == '0);
      sum32      = start_ff[HalfBits-1:0] + div_remainder[HalfBits-1:0];
   end

   always_comb begin
      state_in   = state_ff;
      seed_in    = seed_ff;
      stream_in  = stream_ff;
      wide_in    = wide_ff;
      reload_in  = reload_ff;
      counter_in = counter_ff;
      z_in       = z_ff;
      action_in  = action_ff;
      start_in   = start_ff;
      len_in     = len_ff;
      raw_in     = raw_ff;
      ranged_in  = ranged_ff;
      case (state_ff)
         S_IDLE: begin
            if (csr_beat) begin
               case (csr_index)
                  CSR_SEED: begin
                     seed_in  = csr_wdata;
                     state_in = S_SEED;
                  end
                  CSR_STREAM: begin
                     stream_in = csr_wdata[HalfBits-1:0];
                     state_in  = S_SEED;
                  end
                  CSR_WIDE: begin
                     wide_in = csr_wdata[0];
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end else if (req_beat) begin
               action_in = req_action;
               start_in  = req_range_start;
               len_in    = req_range_len;
               ranged_in = '0;
               if ((req_action == ACT_RANGED) && len_zero) begin
                  raw_in    = '0;
                  ranged_in = wide_ff ? word_type'(req_range_start)
                     : {{HalfBits{req_range_start[HalfBits-1]}}, req_range_start[HalfBits-1:0]};
                  state_in  = S_RSP;
               end else begin
                  counter_in = step_state;
                  z_in       = step_state;
                  reload_in  = 1'b0;
                  state_in   = S_M1;
               end
            end
         end
         S_SEED: begin
            reload_in = 1'b1;
            state_in  = S_SEED_W;
         end
         S_SEED_W: begin
            if (mul_done) begin
               z_in     = trim(wide_ff, seed_ff ^ mul_product);
               state_in = S_M1;
            end
         end
         S_M1: begin
            state_in = S_M1_W;
         end
         S_M1_W: begin
            if (mul_done) begin
               z_in     = prod_t;
               state_in = S_M2;
            end
         end
         S_M2: begin
            state_in = S_M2_W;
         end
         S_M2_W: begin
            if (mul_done) begin
               if (reload_ff) begin
                  counter_in = fin;
                  state_in   = S_IDLE;
               end else begin
                  raw_in   = fin;
                  state_in = (action_ff == ACT_RANGED) ? S_DIV : S_RSP;
               end
            end
         end
         S_DIV: begin
            state_in = S_DIV_W;
         end
         S_DIV_W: begin
            if (div_done) begin
               ranged_in = wide_ff ? (start_ff + div_remainder)
                                   : {{HalfBits{sum32[HalfBits-1]}}, sum32};
               state_in  = S_RSP;
            end
         end
         S_RSP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_SEED;
         seed_ff   <= word_type'(1);
         stream_ff <= '0;
         wide_ff   <= 1'b1;
         reload_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         seed_ff   <= seed_in;
         stream_ff <= stream_in;
         wide_ff   <= wide_in;
         reload_ff <= reload_in;
      end
      counter_ff <= counter_in;
      z_ff       <= z_in;
      action_ff  <= action_in;
      start_ff   <= start_in;
      len_ff     <= len_in;
      raw_ff     <= raw_in;
      ranged_ff  <= ranged_in;
   end

   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(req_beat && csr_beat))
      else $error("request and csr beats in the same cycle");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready && !csr_ready)
      else $error("ready high straight after a request beat");

   a_units_apart: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_done, div_done, mul_start, div_start}))
      else $error("shared units overlap");

   a_rsp_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready && !csr_ready)
      else $error("ready while a response is pending");

endmodule
